>>> design/quadrature_decoder_accel_clamp_core_defines.svh
// Assertion macros shared by the decoder RTL.
// Assertions sample on the rising edge of clock and are held off during reset.
`ifndef QUADRATURE_DECODER_ACCEL_CLAMP_CORE_DEFINES_SVH
`define QUADRATURE_DECODER_ACCEL_CLAMP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define QDAC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qdac check failed");
`define QDAC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qdac check failed");
`else
`define QDAC_ASSERT_IMPL(label, ante, cons)
`define QDAC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/qdac_pkg.sv
`default_nettype none

package qdac_pkg;

   localparam int DivWidth      = 16;
   localparam int DivCountWidth = $clog2(DivWidth + 1);
   localparam int CsrAddrWidth  = 5;
   localparam logic [7:0] MultSat   = 8'd255;
   localparam logic [7:0] FactorCap = 8'd8;

   typedef enum logic [1:0] {
      OP_POLL  = 2'd0,
      OP_READ  = 2'd1,
      OP_SET   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_MIN_POSITION    = 3'd0,
      CSR_MAX_POSITION    = 3'd1,
      CSR_DEBOUNCE_MS     = 3'd2,
      CSR_MIN_INTERVAL_MS = 3'd3,
      CSR_MAX_INTERVAL_MS = 3'd4,
      CSR_ACCEL_THRESHOLD = 3'd5,
      CSR_ACCEL_GAIN      = 3'd6,
      CSR_ACCEL_ENABLE    = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_APPLY,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_start;
      logic apply;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
   } ctrl_status_type;

   // Quadrature transition table, index {old A, old B, new A, new B}.
   function automatic logic signed [1:0] step_dir(input logic [3:0] idx);
      logic signed [1:0] d;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
         default: d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

>>> design/qdac_channel_if.sv
`default_nettype none

interface qdac_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic               pin_a_level;
   logic               pin_b_level;
   logic [31:0]        now_ms;
   logic signed [15:0] new_position;

   modport source (output valid, opcode, pin_a_level, pin_b_level, now_ms, new_position,
                   input ready);
   modport sink (input valid, opcode, pin_a_level, pin_b_level, now_ms, new_position,
                 output ready);
endinterface

interface qdac_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] position;
   logic signed [15:0] change;
   logic signed [4:0]  applied_step;
   logic               sampled;
   logic [7:0]         current_multiplier;

   modport source (output valid, position, change, applied_step, sampled, current_multiplier,
                   input ready);
   modport sink (input valid, position, change, applied_step, sampled, current_multiplier,
                 output ready);
endinterface

`default_nettype wire

>>> design/quadrature_decoder_accel_clamp_core.sv
// Each item passes through the update, launch, divide and apply states; the result is
// registered in the apply state and offered for transfer in the respond state.
// One item at a time; the next input is taken the cycle after the result transfer.
// The divide state waits on the radix-2 divider that forms the acceleration ramp.
// Reset (synchronous, active high) returns configuration and decoder state to defaults.
`default_nettype none

module quadrature_decoder_accel_clamp_core
   import qdac_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   qdac_req_if.sink                     req_chan,
   qdac_rsp_if.source                   rsp_chan,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_pready = 1'b1;

   qdac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   qdac_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_opcode             (req_chan.opcode),
      .req_pin_a_level        (req_chan.pin_a_level),
      .req_pin_b_level        (req_chan.pin_b_level),
      .req_now_ms             (req_chan.now_ms),
      .req_new_position       (req_chan.new_position),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .rsp_position           (rsp_chan.position),
      .rsp_change             (rsp_chan.change),
      .rsp_applied_step       (rsp_chan.applied_step),
      .rsp_sampled            (rsp_chan.sampled),
      .rsp_current_multiplier (rsp_chan.current_multiplier)
   );

endmodule

`default_nettype wire

>>> design/qdac_divider.sv
`default_nettype none
`include "quadrature_decoder_accel_clamp_core_defines.svh"

module qdac_divider
   import qdac_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DivWidth-1:0] dividend,
   input  wire logic [7:0]          divisor,
   output logic [DivWidth-1:0]      quotient,
   output logic                     done
);

   logic [DivWidth-1:0]      quot_ff, quot_in;
   logic [7:0]               rem_ff, rem_in;
   logic [7:0]               divisor_ff, divisor_in;
   logic [DivCountWidth-1:0] count_ff, count_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   logic [8:0] rem_sh;
   logic [8:0] rem_sub;
   logic       fits;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      rem_sh  = {rem_ff, quot_ff[DivWidth-1]};
      rem_sub = rem_sh - {1'b0, divisor_ff};
      fits    = rem_sh >= {1'b0, divisor_ff};

      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         quot_in    = dividend;
         rem_in     = 8'd0;
         divisor_in = divisor;
         count_in   = DivCountWidth'(DivWidth);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[DivWidth-2:0], fits};
         rem_in   = fits ? rem_sub[7:0] : rem_sh[7:0];
         count_in = count_ff - 1'b1;
         if (count_ff == DivCountWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

   `QDAC_ASSERT_IMPL(a_done_after_busy, done_ff, $past(busy_ff) && !busy_ff)

endmodule

`default_nettype wire

>>> design/qdac_datapath.sv
`default_nettype none
`include "quadrature_decoder_accel_clamp_core_defines.svh"

module qdac_datapath
   import qdac_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctrl_cmd_type            cmd,
   output ctrl_status_type              status,
   input  wire logic [1:0]              req_opcode,
   input  wire logic                    req_pin_a_level,
   input  wire logic                    req_pin_b_level,
   input  wire logic [31:0]             req_now_ms,
   input  wire logic signed [15:0]      req_new_position,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic signed [15:0]           rsp_position,
   output logic signed [15:0]           rsp_change,
   output logic signed [4:0]            rsp_applied_step,
   output logic                         rsp_sampled,
   output logic [7:0]                   rsp_current_multiplier
);

   // Configuration registers
   logic signed [15:0] min_pos_ff, max_pos_ff;
   logic [7:0]         debounce_ff, min_int_ff, max_int_ff, thresh_ff, gain_ff;
   logic               accel_en_ff;

   logic          csr_wr;
   csr_index_type csr_idx;

   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_index_type'(csr_paddr[CsrAddrWidth-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pos_ff  <= -16'sd32768;
         max_pos_ff  <= 16'sd32767;
         debounce_ff <= 8'd0;
         min_int_ff  <= 8'd5;
         max_int_ff  <= 8'd80;
         thresh_ff   <= 8'd3;
         gain_ff     <= 8'd3;
         accel_en_ff <= 1'b1;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_MIN_POSITION:    min_pos_ff  <= signed'(csr_pwdata[15:0]);
            CSR_MAX_POSITION:    max_pos_ff  <= signed'(csr_pwdata[15:0]);
            CSR_DEBOUNCE_MS:     debounce_ff <= csr_pwdata[7:0];
            CSR_MIN_INTERVAL_MS: min_int_ff  <= csr_pwdata[7:0];
            CSR_MAX_INTERVAL_MS: max_int_ff  <= csr_pwdata[7:0];
            CSR_ACCEL_THRESHOLD: thresh_ff   <= csr_pwdata[7:0];
            CSR_ACCEL_GAIN:      gain_ff     <= csr_pwdata[7:0];
            CSR_ACCEL_ENABLE:    accel_en_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_MIN_POSITION:    csr_prdata = {16'd0, min_pos_ff};
         CSR_MAX_POSITION:    csr_prdata = {16'd0, max_pos_ff};
         CSR_DEBOUNCE_MS:     csr_prdata = {24'd0, debounce_ff};
         CSR_MIN_INTERVAL_MS: csr_prdata = {24'd0, min_int_ff};
         CSR_MAX_INTERVAL_MS: csr_prdata = {24'd0, max_int_ff};
         CSR_ACCEL_THRESHOLD: csr_prdata = {24'd0, thresh_ff};
         CSR_ACCEL_GAIN:      csr_prdata = {24'd0, gain_ff};
         CSR_ACCEL_ENABLE:    csr_prdata = {31'd0, accel_en_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // Item capture
   op_type             op_ff;
   logic [1:0]         pins_ff;
   logic [31:0]        now_ff;
   logic signed [15:0] newpos_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= op_type'(req_opcode);
         pins_ff   <= {req_pin_a_level, req_pin_b_level};
         now_ff    <= req_now_ms;
         newpos_ff <= req_new_position;
      end
   end

   // Decoder state
   logic [1:0]         prev_pins_ff, prev_pins_in;
   logic signed [15:0] pos_ff, pos_in;
   logic signed [15:0] last_read_ff, last_read_in;
   logic [31:0]        last_sample_ff, last_sample_in;
   logic [31:0]        last_event_ff, last_event_in;
   logic [7:0]         spacing_ff, spacing_in;
   logic [7:0]         fast_ff, fast_in;
   logic               sample_ff, sample_in;
   logic signed [1:0]  dir_ff, dir_in;

   // Debounce gate and event timing, evaluated in the update cycle
   logic [31:0] elapsed;
   logic        gate;
   logic        accel_go;
   logic [31:0] spacing_raw, spacing_up;
   logic        over;
   logic [8:0]  mid_sum;
   logic [7:0]  fast_sat;

   always_comb begin
      elapsed     = now_ff - last_sample_ff;
      gate        = (op_ff == OP_POLL) && (elapsed >= {24'd0, debounce_ff});
      dir_in      = step_dir({prev_pins_ff, pins_ff});
      accel_go    = gate && (dir_in != 2'sd0) && accel_en_ff;
      spacing_raw = now_ff - last_event_ff;
      spacing_up  = (spacing_raw < {24'd0, min_int_ff}) ? {24'd0, min_int_ff} : spacing_raw;
      over        = spacing_up > {24'd0, max_int_ff};
      mid_sum     = {1'b0, min_int_ff} + {1'b0, max_int_ff};
      fast_sat    = (fast_ff == MultSat) ? fast_ff : fast_ff + 8'd1;
      sample_in   = gate;

      prev_pins_in   = prev_pins_ff;
      last_sample_in = last_sample_ff;
      last_event_in  = last_event_ff;
      spacing_in     = spacing_ff;
      fast_in        = fast_ff;
      if (cmd.update) begin
         if (op_ff == OP_CLEAR) begin
            fast_in        = 8'd0;
            last_event_in  = now_ff;
            last_sample_in = now_ff;
         end
         if (gate) begin
            prev_pins_in   = pins_ff;
            last_sample_in = now_ff;
         end
         if (accel_go) begin
            last_event_in = now_ff;
            if (over) begin
               spacing_in = max_int_ff;
               fast_in    = 8'd0;
            end else begin
               spacing_in = spacing_up[7:0];
               fast_in    = (spacing_up[7:0] < mid_sum[8:1]) ? fast_sat : 8'd0;
            end
         end
      end
   end

   // Ramp 1 + (max - spacing) * (gain - 1) / (max - min) on the stored spacing
   logic [7:0]          ramp_diff, gain_m1, ramp_range;
   logic [DivWidth-1:0] ramp_num, quot;
   logic                div_done;

   assign ramp_diff  = (spacing_ff > max_int_ff) ? 8'd0 : max_int_ff - spacing_ff;
   assign gain_m1    = (gain_ff == 8'd0) ? 8'd0 : gain_ff - 8'd1;
   assign ramp_num   = {8'd0, ramp_diff} * {8'd0, gain_m1};
   assign ramp_range = max_int_ff - min_int_ff;

   qdac_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (ramp_num),
      .divisor  (ramp_range),
      .quotient (quot),
      .done     (div_done)
   );

   assign status.div_done = div_done;

   // Apply cycle: factor, step, clamped position, result
   logic [DivWidth:0]  ramp_q;
   logic [7:0]         query;
   logic [3:0]         factor;
   logic signed [4:0]  step_mag, step;
   logic               stepping;
   logic signed [16:0] sum17, max17, min17, new17;
   logic signed [15:0] poll_pos, set_pos;
   logic signed [15:0] change_in;
   logic signed [4:0]  step_out;

   always_comb begin
      ramp_q = {1'b0, quot} + 17'd1;
      if (accel_en_ff && (fast_ff >= thresh_ff) && (max_int_ff > min_int_ff)) begin
         query = (ramp_q > {9'd0, MultSat}) ? MultSat : ramp_q[7:0];
      end else begin
         query = 8'd1;
      end
      factor   = (query > FactorCap) ? FactorCap[3:0] : query[3:0];
      step_mag = signed'({1'b0, factor});
      step     = (dir_ff == -2'sd1) ? -step_mag : step_mag;
      stepping = (op_ff == OP_POLL) && sample_ff && (dir_ff != 2'sd0);

      sum17 = {pos_ff[15], pos_ff} + {{12{step[4]}}, step};
      max17 = {max_pos_ff[15], max_pos_ff};
      min17 = {min_pos_ff[15], min_pos_ff};
      new17 = {newpos_ff[15], newpos_ff};
      if (sum17 > max17) begin
         poll_pos = max_pos_ff;
      end else if (sum17 < min17) begin
         poll_pos = min_pos_ff;
      end else begin
         poll_pos = sum17[15:0];
      end
      // set position checks the floor first
      if (new17 < min17) begin
         set_pos = min_pos_ff;
      end else if (new17 > max17) begin
         set_pos = max_pos_ff;
      end else begin
         set_pos = newpos_ff;
      end

      pos_in       = pos_ff;
      last_read_in = last_read_ff;
      change_in    = 16'sd0;
      step_out     = stepping ? step : 5'sd0;
      if (cmd.apply) begin
         case (op_ff)
            OP_POLL: begin
               if (stepping) begin
                  pos_in = poll_pos;
               end
            end
            OP_READ: begin
               change_in    = pos_ff - last_read_ff;
               last_read_in = pos_ff;
            end
            OP_SET: begin
               pos_in       = set_pos;
               last_read_in = set_pos;
            end
            OP_CLEAR: begin
               pos_in       = 16'sd0;
               last_read_in = 16'sd0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff   <= 2'd0;
         pos_ff         <= 16'sd0;
         last_read_ff   <= 16'sd0;
         last_sample_ff <= 32'd0;
         last_event_ff  <= 32'd0;
         spacing_ff     <= 8'd0;
         fast_ff        <= 8'd0;
         sample_ff      <= 1'b0;
         dir_ff         <= 2'sd0;
      end else begin
         prev_pins_ff   <= prev_pins_in;
         pos_ff         <= pos_in;
         last_read_ff   <= last_read_in;
         last_sample_ff <= last_sample_in;
         last_event_ff  <= last_event_in;
         spacing_ff     <= spacing_in;
         fast_ff        <= fast_in;
         if (cmd.update) begin
            sample_ff <= sample_in;
            dir_ff    <= dir_in;
         end
      end
   end

   // Result register
   logic signed [15:0] rsp_pos_ff, rsp_change_ff;
   logic signed [4:0]  rsp_step_ff;
   logic               rsp_sampled_ff;
   logic [7:0]         rsp_mult_ff;

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_pos_ff     <= pos_in;
         rsp_change_ff  <= change_in;
         rsp_step_ff    <= step_out;
         rsp_sampled_ff <= sample_ff;
         rsp_mult_ff    <= query;
      end
   end

   assign rsp_position           = rsp_pos_ff;
   assign rsp_change             = rsp_change_ff;
   assign rsp_applied_step       = rsp_step_ff;
   assign rsp_sampled            = rsp_sampled_ff;
   assign rsp_current_multiplier = rsp_mult_ff;

   `QDAC_ASSERT_NEXT(a_step_range, cmd.apply, (rsp_step_ff <= 5'sd8) && (rsp_step_ff >= -5'sd8))
   `QDAC_ASSERT_NEXT(a_mult_nonzero, cmd.apply, rsp_mult_ff != 8'd0)
   `QDAC_ASSERT_IMPL(a_sample_poll_only, cmd.apply && sample_ff, op_ff == OP_POLL)

endmodule

`default_nettype wire

>>> design/qdac_ctrl.sv
`default_nettype none
`include "quadrature_decoder_accel_clamp_core_defines.svh"

module qdac_ctrl
   import qdac_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output ctrl_cmd_type         cmd,
   input  wire ctrl_status_type status
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_UPDATE:  cmd.update    = 1'b1;
         ST_LAUNCH:  cmd.div_start = 1'b1;
         ST_DIVIDE:  ;
         ST_APPLY:   cmd.apply     = 1'b1;
         ST_RESPOND: rsp_valid     = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `QDAC_ASSERT_IMPL(a_done_while_waiting, status.div_done, state_ff == ST_DIVIDE)
   `QDAC_ASSERT_NEXT(a_capture_then_update, cmd.capture, cmd.update && !req_ready)

endmodule

`default_nettype wire

>>> tb/tb_quadrature_decoder_accel_clamp_core.sv
`timescale 1ns / 100ps

module tb_quadrature_decoder_accel_clamp_core;
   import qdac_pkg::*;

   localparam int CycleLimit = 400000;

   typedef struct {
      op_type             opcode;
      logic               pin_a;
      logic               pin_b;
      logic [31:0]        now_ms;
      logic signed [15:0] new_position;
   } decode_req_type;

   typedef struct {
      logic signed [15:0] position;
      logic signed [15:0] change;
      logic signed [4:0]  applied_step;
      logic               sampled;
      logic [7:0]         current_multiplier;
   } decode_rsp_type;

   // direction by {old A, old B, new A, new B}
   localparam int QuadDir [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

   logic clock;
   logic reset;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [31:0]             csr_pwdata;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   qdac_req_if req_bus ();
   qdac_rsp_if rsp_bus ();

   quadrature_decoder_accel_clamp_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor copy of configuration
   logic signed [15:0] c_min_pos;
   logic signed [15:0] c_max_pos;
   logic [7:0]         c_debounce;
   logic [7:0]         c_min_iv;
   logic [7:0]         c_max_iv;
   logic [7:0]         c_thresh;
   logic [7:0]         c_gain;
   logic               c_accel_en;

   // predictor copy of decoder state
   logic [1:0]         m_pins;
   logic signed [15:0] m_pos;
   logic signed [15:0] m_last_read;
   logic [31:0]        m_sample_ms;
   logic [31:0]        m_event_ms;
   logic [7:0]         m_spacing;
   logic [7:0]         m_fast_cnt;

   decode_rsp_type pending_decodes[$];
   decode_rsp_type head_rsp;

   int fail_count;
   int cycle_count;
   int sender_idle_pct;
   int rsp_stall_pct;
   int rsp_hold;

   // stimulus tracking: encoder phase, turning direction, time base
   logic [1:0]  gray_pos;
   int          spin_dir;
   logic [31:0] clock_ms;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int unsigned ramp_value(input logic [7:0] spacing);
      int unsigned span, diff, g1, q;
      if (c_max_iv <= c_min_iv) return 1;
      span = c_max_iv - c_min_iv;
      diff = (spacing > c_max_iv) ? 0 : c_max_iv - spacing;
      g1 = (c_gain != 0) ? c_gain - 1 : 0;
      q = 1 + (diff * g1) / span;
      return (q > 255) ? 255 : q;
   endfunction

   function automatic int unsigned accel_step_factor(input logic [31:0] now);
      logic [31:0] spacing;
      int unsigned mid, f;
      if (!c_accel_en) return 1;
      spacing = now - m_event_ms;
      m_event_ms = now;
      if (spacing < c_min_iv) spacing = {24'd0, c_min_iv};
      if (spacing > c_max_iv) begin
         m_spacing = c_max_iv;
         m_fast_cnt = 8'd0;
         return 1;
      end
      m_spacing = spacing[7:0];
      mid = (c_min_iv + c_max_iv) >> 1;
      if (spacing < mid) begin
         if (m_fast_cnt != 8'd255) m_fast_cnt = m_fast_cnt + 8'd1;
      end else begin
         m_fast_cnt = 8'd0;
      end
      if (m_fast_cnt >= c_thresh) begin
         f = ramp_value(spacing[7:0]);
         if (f > 8) f = 8;
         if (f < 1) f = 1;
         return f;
      end
      return 1;
   endfunction

   function automatic decode_rsp_type predict_decode(input decode_req_type it);
      decode_rsp_type r;
      logic [1:0] pins;
      int p, dir, stepv;
      r.change = '0;
      r.applied_step = '0;
      r.sampled = 1'b0;
      case (it.opcode)
         OP_POLL: begin
            if ((it.now_ms - m_sample_ms) >= c_debounce) begin
               pins = {it.pin_a, it.pin_b};
               dir = QuadDir[{m_pins, pins}];
               r.sampled = 1'b1;
               if (dir != 0) begin
                  stepv = dir * int'(accel_step_factor(it.now_ms));
                  p = int'(m_pos) + stepv;
                  if (p > int'(c_max_pos)) p = c_max_pos;
                  else if (p < int'(c_min_pos)) p = c_min_pos;
                  m_pos = 16'(p);
                  r.applied_step = 5'(stepv);
               end
               m_pins = pins;
               m_sample_ms = it.now_ms;
            end
         end
         OP_READ: begin
            r.change = m_pos - m_last_read;
            m_last_read = m_pos;
         end
         OP_SET: begin
            p = int'(it.new_position);
            if (p < int'(c_min_pos)) p = c_min_pos;
            else if (p > int'(c_max_pos)) p = c_max_pos;
            m_pos = 16'(p);
            m_last_read = 16'(p);
         end
         default: begin
            m_pos = '0;
            m_last_read = '0;
            m_fast_cnt = 8'd0;
            m_event_ms = it.now_ms;
            m_sample_ms = it.now_ms;
         end
      endcase
      r.position = m_pos;
      r.current_multiplier = (!c_accel_en || m_fast_cnt < c_thresh) ? 8'd1 :
                             8'(ramp_value(m_spacing));
      return r;
   endfunction

   function automatic logic [1:0] gray_pins(input logic [1:0] g);
      return {g[1], g[1] ^ g[0]};
   endfunction

   function automatic decode_req_type mk_item(input op_type op, input logic [1:0] pins,
                                              input logic [31:0] now,
                                              input logic signed [15:0] newpos);
      decode_req_type it;
      it.opcode = op;
      it.pin_a = pins[1];
      it.pin_b = pins[0];
      it.now_ms = now;
      it.new_position = newpos;
      return it;
   endfunction

   function automatic decode_req_type random_item();
      int unsigned roll, r2;
      logic [31:0] dt;
      r2 = $urandom_range(0, 99);
      if (r2 < 55) dt = $urandom_range(0, 12);
      else if (r2 < 80) dt = $urandom_range(13, 90);
      else if (r2 < 92) dt = $urandom_range(90, 400);
      else if (r2 < 97) dt = $urandom_range(0, 300);
      else dt = $urandom;
      clock_ms = clock_ms + dt;
      roll = $urandom_range(0, 99);
      if (roll < 82) begin
         if ($urandom_range(0, 99) < 5) spin_dir = -spin_dir;
         r2 = $urandom_range(0, 99);
         if (r2 >= 85) gray_pos = 2'($urandom_range(0, 3));
         else if (r2 < 75) gray_pos = 2'(gray_pos + spin_dir);
         return mk_item(OP_POLL, gray_pins(gray_pos), clock_ms, 16'($urandom));
      end
      if (roll < 89) return mk_item(OP_READ, 2'($urandom), clock_ms, 16'($urandom));
      if (roll < 95) begin
         if ($urandom_range(0, 9) < 7)
            return mk_item(OP_SET, 2'($urandom), clock_ms, 16'($urandom));
         return mk_item(OP_SET, 2'($urandom), clock_ms,
                        16'(int'($urandom_range(0, 200)) - 100));
      end
      return mk_item(OP_CLEAR, 2'($urandom), clock_ms, 16'($urandom));
   endfunction

   function automatic void check_field(input string field, input int expv, input int actv);
      if (expv != actv) begin
         $error("%s mismatch: expected %0d, got %0d", field, expv, actv);
         fail_count++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_decodes.size() == 0) begin
            $error("result transfer with nothing pending");
            fail_count++;
         end else begin
            head_rsp = pending_decodes.pop_front();
            check_field("position", head_rsp.position, rsp_bus.position);
            check_field("change", head_rsp.change, rsp_bus.change);
            check_field("applied_step", head_rsp.applied_step, rsp_bus.applied_step);
            check_field("sampled", head_rsp.sampled, rsp_bus.sampled);
            check_field("current_multiplier", head_rsp.current_multiplier,
                        rsp_bus.current_multiplier);
         end
      end
   end

   // receiver: random stalls plus an optional long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL quadrature_decoder_accel_clamp_core");
      $finish;
   end

   // returns at the accepting edge with valid still high; at the following falling edge
   // the next call drives its own item or drops valid, and wait_drained takes it down
   task automatic send_item(input decode_req_type it);
      @(negedge clock);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= it.opcode;
      req_bus.pin_a_level <= it.pin_a;
      req_bus.pin_b_level <= it.pin_b;
      req_bus.now_ms <= it.now_ms;
      req_bus.new_position <= it.new_position;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_decodes.push_back(predict_decode(it));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
   endtask

   task automatic poll_step(input int dir, input int unsigned dt);
      clock_ms = clock_ms + dt;
      gray_pos = 2'(gray_pos + dir);
      send_item(mk_item(OP_POLL, gray_pins(gray_pos), clock_ms, 16'sd0));
   endtask

   task automatic send_op(input op_type op, input int newpos, input int unsigned dt);
      clock_ms = clock_ms + dt;
      send_item(mk_item(op, gray_pins(gray_pos), clock_ms, 16'(newpos)));
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         CSR_MIN_POSITION:    c_min_pos = value[15:0];
         CSR_MAX_POSITION:    c_max_pos = value[15:0];
         CSR_DEBOUNCE_MS:     c_debounce = value[7:0];
         CSR_MIN_INTERVAL_MS: c_min_iv = value[7:0];
         CSR_MAX_INTERVAL_MS: c_max_iv = value[7:0];
         CSR_ACCEL_THRESHOLD: c_thresh = value[7:0];
         CSR_ACCEL_GAIN:      c_gain = value[7:0];
         default:             c_accel_en = value[0];
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_config(input int min_pos, input int max_pos, input int deb,
                               input int min_iv, input int max_iv, input int thr,
                               input int gain, input int en);
      wait_drained();
      write_csr(CSR_MIN_POSITION, 32'(min_pos));
      write_csr(CSR_MAX_POSITION, 32'(max_pos));
      write_csr(CSR_DEBOUNCE_MS, 32'(deb));
      write_csr(CSR_MIN_INTERVAL_MS, 32'(min_iv));
      write_csr(CSR_MAX_INTERVAL_MS, 32'(max_iv));
      write_csr(CSR_ACCEL_THRESHOLD, 32'(thr));
      write_csr(CSR_ACCEL_GAIN, 32'(gain));
      write_csr(CSR_ACCEL_ENABLE, 32'(en));
   endtask

   // reset config: a slow first step clears the ramp, then fast steps build it up
   task automatic test_default_accel();
      poll_step(1, 1000);
      poll_step(1, 3);
      poll_step(1, 3);
      poll_step(1, 3);
      poll_step(1, 21);
      poll_step(-1, 10);
      poll_step(0, 1);
      send_op(OP_READ, 0, 0);
      // diagonal jump is not a valid transition
      gray_pos = 2'(gray_pos + 2);
      send_item(mk_item(OP_POLL, gray_pins(gray_pos), clock_ms + 9, 16'sd0));
      clock_ms = clock_ms + 9;
   endtask

   task automatic test_opcode_extremes();
      send_op(OP_SET, 32767, 0);
      poll_step(-1, 2);
      send_op(OP_SET, -32768, 0);
      poll_step(1, 2);
      send_op(OP_READ, 0, 1);
      clock_ms = 32'hFFFF_FFFF;
      send_op(OP_CLEAR, 0, 0);
      // time base wraps through zero
      poll_step(-1, 3);
      send_op(OP_READ, 0, 0);
   endtask

   task automatic test_clamp_corners();
      apply_config(-10, 10, 0, 5, 80, 3, 3, 1);
      send_op(OP_SET, 100, 1);
      poll_step(-1, 50);
      send_op(OP_SET, -100, 1);
      poll_step(1, 50);
      // floor above ceiling
      apply_config(5, -5, 0, 5, 80, 3, 3, 1);
      send_op(OP_SET, 0, 1);
      poll_step(-1, 50);
   endtask

   task automatic test_accel_corners();
      // zero interval range
      apply_config(-32768, 32767, 0, 20, 20, 0, 8, 1);
      poll_step(1, 5);
      // zero gain
      apply_config(-32768, 32767, 0, 0, 200, 0, 0, 1);
      poll_step(1, 1);
      apply_config(-32768, 32767, 0, 0, 200, 0, 255, 1);
      poll_step(1, 0);
      // narrowed range makes the query saturate
      apply_config(-32768, 32767, 0, 199, 200, 0, 255, 1);
      send_op(OP_READ, 0, 0);
      apply_config(-32768, 32767, 0, 0, 200, 0, 9, 1);
      poll_step(1, 150);
      // stored spacing now beyond the ceiling
      apply_config(-32768, 32767, 0, 0, 100, 0, 9, 1);
      send_op(OP_READ, 0, 0);
      apply_config(-32768, 32767, 0, 5, 80, 3, 3, 0);
      poll_step(1, 1);
      apply_config(-32768, 32767, 255, 5, 80, 3, 3, 1);
      poll_step(1, 10);
      poll_step(1, 255);
   endtask

   task automatic test_backpressure();
      apply_config(-1000, 1000, 0, 5, 80, 2, 4, 1);
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold = 400;
      repeat (10) send_item(random_item());
      wait_drained();
   endtask

   task automatic randomize_config();
      int lo, hi, deb, miv, xiv, thr, gain, en, r;
      r = $urandom_range(0, 4);
      case (r)
         0: begin
            lo = -32768;
            hi = 32767;
         end
         1: begin
            lo = 0 - int'($urandom_range(1, 60));
            hi = $urandom_range(1, 60);
         end
         2: begin
            lo = int'($urandom_range(0, 65535)) - 32768;
            hi = int'($urandom_range(0, 65535)) - 32768;
         end
         3: begin
            lo = int'($urandom_range(0, 20)) - 10;
            hi = lo;
         end
         default: begin
            lo = 32700;
            hi = 32767;
         end
      endcase
      r = $urandom_range(0, 99);
      deb = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 8) : $urandom_range(0, 255);
      miv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 30);
      r = $urandom_range(0, 99);
      if (r < 60) xiv = miv + $urandom_range(1, 120);
      else if (r < 70) xiv = 255;
      else if (r < 85) xiv = miv;
      else xiv = $urandom_range(0, 255);
      thr = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 5) : $urandom_range(0, 255);
      r = $urandom_range(0, 99);
      gain = (r < 60) ? $urandom_range(1, 9) : (r < 90) ? $urandom_range(1, 255) : 255;
      en = ($urandom_range(0, 99) < 85) ? 1 : 0;
      apply_config(lo, hi, deb, miv, xiv, thr, gain, en);
   endtask

   task automatic test_random_phases();
      int snd_pct [4] = '{0, 60, 0, 22};
      int rcv_pct [4] = '{0, 0, 60, 22};
      for (int ph = 0; ph < 8; ph++) begin
         randomize_config();
         sender_idle_pct = snd_pct[ph % 4];
         rsp_stall_pct = rcv_pct[ph % 4];
         if ($urandom_range(0, 4) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
         else if ($urandom_range(0, 1) == 0) clock_ms = $urandom;
         repeat (90) send_item(random_item());
         wait_drained();
      end
   endtask

   initial begin
      fail_count = 0;
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold = 0;
      gray_pos = 2'd0;
      spin_dir = 1;
      clock_ms = 32'd0;
      c_min_pos = -16'sd32768;
      c_max_pos = 16'sd32767;
      c_debounce = 8'd0;
      c_min_iv = 8'd5;
      c_max_iv = 8'd80;
      c_thresh = 8'd3;
      c_gain = 8'd3;
      c_accel_en = 1'b1;
      m_pins = 2'd0;
      m_pos = '0;
      m_last_read = '0;
      m_sample_ms = '0;
      m_event_ms = '0;
      m_spacing = '0;
      m_fast_cnt = '0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_POLL;
      req_bus.pin_a_level = 1'b0;
      req_bus.pin_b_level = 1'b0;
      req_bus.now_ms = '0;
      req_bus.new_position = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_accel();
      test_opcode_extremes();
      test_clamp_corners();
      test_accel_corners();
      test_backpressure();
      test_random_phases();

      wait_drained();
      repeat (30) @(posedge clock);
      if (pending_decodes.size() != 0) begin
         $error("%0d expected results never arrived", pending_decodes.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("PASS quadrature_decoder_accel_clamp_core");
      end else begin
         $display("FAIL quadrature_decoder_accel_clamp_core");
      end
      $finish;
   end

endmodule
